// ===== rtl/core/lfr_pkg.sv =====
// Package for the LRU frame replacer: sizes, request codes and the control
// struct that the top level hands to the row of slot cells. No dependencies.
package lfr_pkg;

  localparam int SLOTS      = 16;
  localparam int FRAME_BITS = 10;

  // Count of held frames must reach SLOTS itself.
  localparam int CNT_W = $clog2(SLOTS + 1);
  // Slot index width, at least one bit.
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed field widths of the ports.
  localparam int CAP_W  = 5;
  localparam int OCC_W  = 5;
  localparam int MODE_W = 2;

  // Common width for comparing the count with the capacity register.
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_VICTIM = 2'd0,
    MODE_PIN    = 2'd1,
    MODE_UNPIN  = 2'd2
  } mode_e;

  // Per-cycle command broadcast to every slot cell.
  typedef struct packed {
    logic                  insert;  // shift toward the back, id enters slot 0
    logic                  remove;  // close the gap at the matching slot
    logic [FRAME_BITS-1:0] id;      // frame id being searched or inserted
  } lfr_ctrl_t;

endpackage

// ===== rtl/core/lru_frame_replacer.sv =====
// Top level of the LRU frame replacer: request decode, held count, capacity
// register and result register. Depends on lfr_pkg and lfr_chain.

// The replacer keeps an ordered list of evictable frame ids in a row of
// SLOTS cells, most recently unpinned frame in slot 0. Each request beat
// carries a mode and a frame id: unpin puts the frame at the front unless it
// is already held or the list has reached the capacity register (capacity
// above SLOTS counts as SLOTS, zero blocks every insert); pin removes the
// frame if held and the cells behind it move up one place; victim removes
// the oldest frame and returns it, or reports none found on an empty list.
// Every request gives exactly one result beat with victim_found,
// victim_frame (zero when nothing was found) and the occupancy after the
// request. Every cell compares its id with the request at once, the hit
// ripples down the row and all cells shift in the same edge, so a new
// request is taken each cycle while the result register can hand its beat
// on. The input stalls only while a finished result waits on a stalled
// output. The user must write capacity through cfg_we_i and cfg_data_i only
// while the block is idle; the block itself does not enforce it. Slot
// contents have no reset; only slots below the held count are ever read.
module lru_frame_replacer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfr_pkg::CAP_W-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lfr_pkg::MODE_W-1:0]     mode_i,
  input  logic [lfr_pkg::FRAME_BITS-1:0] frame_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          victim_found_o,
  output logic [lfr_pkg::FRAME_BITS-1:0] victim_frame_o,
  output logic [lfr_pkg::OCC_W-1:0]      occupancy_o
);

  logic [lfr_pkg::CAP_W-1:0]      cap_q;
  logic [lfr_pkg::CNT_W-1:0]      held_q, held_d;
  logic                           out_valid_q;
  logic                           found_q, found_d;
  logic [lfr_pkg::FRAME_BITS-1:0] frame_q, frame_d;
  logic [lfr_pkg::OCC_W-1:0]      occ_q;

  logic                           accept;
  lfr_pkg::lfr_ctrl_t             ctrl;
  logic                           hit;
  logic [lfr_pkg::FRAME_BITS-1:0] slot [lfr_pkg::SLOTS];
  logic [lfr_pkg::CMP_W-1:0]      cap_ext;
  logic [lfr_pkg::CMP_W-1:0]      held_ext;
  logic [lfr_pkg::CMP_W-1:0]      held_d_ext;
  logic [lfr_pkg::CMP_W-1:0]      cap_lim;
  logic [lfr_pkg::CNT_W-1:0]      last_cnt;
  logic [lfr_pkg::IDX_W-1:0]      last_idx;

  // A new beat is taken whenever the result register is empty or draining.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Capacity saturates at the number of slots.
  assign cap_ext  = lfr_pkg::CMP_W'(cap_q);
  assign held_ext = lfr_pkg::CMP_W'(held_q);
  assign cap_lim  = (cap_ext > lfr_pkg::CMP_W'(lfr_pkg::SLOTS)) ?
                    lfr_pkg::CMP_W'(lfr_pkg::SLOTS) : cap_ext;

  // Oldest held frame sits at slot held_q - 1.
  assign last_cnt = held_q - lfr_pkg::CNT_W'(1);
  assign last_idx = last_cnt[lfr_pkg::IDX_W-1:0];

  always_comb begin
    ctrl.insert = 1'b0;
    ctrl.remove = 1'b0;
    ctrl.id     = frame_id_i;
    held_d      = held_q;
    found_d     = 1'b0;
    frame_d     = '0;
    unique case (lfr_pkg::mode_e'(mode_i))
      lfr_pkg::MODE_VICTIM: begin
        if (held_q != '0) begin
          found_d = 1'b1;
          frame_d = slot[last_idx];
          held_d  = last_cnt;
        end
      end
      lfr_pkg::MODE_PIN: begin
        if (hit) begin
          ctrl.remove = accept;
          held_d      = last_cnt;
        end
      end
      lfr_pkg::MODE_UNPIN: begin
        if ((held_ext < cap_lim) && !hit) begin
          ctrl.insert = accept;
          held_d      = held_q + lfr_pkg::CNT_W'(1);
        end
      end
      default: begin
        // Unused request code leaves the list alone.
      end
    endcase
  end

  assign held_d_ext = lfr_pkg::CMP_W'(held_d);

  lfr_chain u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .held_cnt_i (held_q),
    .hit_o      (hit),
    .slot_o     (slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lfr_pkg::CAP_W'(16);
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        held_q      <= held_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; loaded only with an accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q <= found_d;
      frame_q <= frame_d;
      occ_q   <= held_d_ext[lfr_pkg::OCC_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign victim_found_o = found_q;
  assign victim_frame_o = frame_q;
  assign occupancy_o    = occ_q;

endmodule

// ===== rtl/core/lfr_cell.sv =====
// One slot of the replacer list: holds a frame id, compares it with the
// request id and shifts with its neighbors. Depends on lfr_pkg.
module lfr_cell (
  input  logic                          clk_i,
  input  lfr_pkg::lfr_ctrl_t            ctrl_i,
  input  logic                          held_i,
  input  logic [lfr_pkg::FRAME_BITS-1:0] left_i,
  input  logic [lfr_pkg::FRAME_BITS-1:0] right_i,
  input  logic                          hit_i,
  output logic                          hit_o,
  output logic [lfr_pkg::FRAME_BITS-1:0] val_o
);

  logic [lfr_pkg::FRAME_BITS-1:0] val_q;
  logic [lfr_pkg::FRAME_BITS-1:0] val_d;
  logic                           match;

  assign match = held_i && (val_q == ctrl_i.id);
  // Set at this slot and every slot behind the matching one.
  assign hit_o = hit_i | match;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert) begin
      val_d = left_i;
    end else if (ctrl_i.remove && hit_o) begin
      val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== rtl/core/lfr_chain.sv =====
// Row of slot cells that forms the ordered list, front at slot 0.
// Depends on lfr_pkg and lfr_cell.
module lfr_chain (
  input  logic                          clk_i,
  input  lfr_pkg::lfr_ctrl_t            ctrl_i,
  input  logic [lfr_pkg::CNT_W-1:0]     held_cnt_i,
  output logic                          hit_o,
  output logic [lfr_pkg::FRAME_BITS-1:0] slot_o [lfr_pkg::SLOTS]
);

  logic                           hit [lfr_pkg::SLOTS+1];
  logic [lfr_pkg::FRAME_BITS-1:0] val [lfr_pkg::SLOTS];

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < lfr_pkg::SLOTS; i++) begin : g_cell
    logic [lfr_pkg::FRAME_BITS-1:0] left;
    logic [lfr_pkg::FRAME_BITS-1:0] right;
    logic                           held;

    if (i == 0) begin : g_front
      assign left = ctrl_i.id;
    end else begin : g_mid_l
      assign left = val[i-1];
    end

    if (i == lfr_pkg::SLOTS - 1) begin : g_back
      assign right = val[i];
    end else begin : g_mid_r
      assign right = val[i+1];
    end

    assign held = (lfr_pkg::CNT_W'(i) < held_cnt_i);

    lfr_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .held_i  (held),
      .left_i  (left),
      .right_i (right),
      .hit_i   (hit[i]),
      .hit_o   (hit[i+1]),
      .val_o   (val[i])
    );

    assign slot_o[i] = val[i];
  end

  assign hit_o = hit[lfr_pkg::SLOTS];

endmodule
